/* rtl/direct_mapped_cache_tags_macros.svh */
// Assertion macros shared by the tag store RTL.
`ifndef DIRECT_MAPPED_CACHE_TAGS_MACROS_SVH
`define DIRECT_MAPPED_CACHE_TAGS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DMCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DMCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dmct_pkg.sv */
// Types and constants of the direct-mapped cache tag store.
package dmct_pkg;

  // Command field
  localparam int CMD_W = 2;
  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_ACCESS  = 2'd0;
  localparam cmd_t CMD_PROBE   = 2'd1;
  localparam cmd_t CMD_INV_ALL = 2'd2;
  localparam cmd_t CMD_INV_ONE = 2'd3;

  // Latency registers
  localparam int HIT_LAT_W  = 8;
  localparam int LAT_W      = 10;
  localparam int CFG_DATA_W = LAT_W;
  localparam int CFG_IDX_W  = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HIT_LAT  = 1'b0;
  localparam cfg_idx_t CFG_MISS_LAT = 1'b1;
  localparam logic [HIT_LAT_W-1:0] HIT_LAT_RST  = 8'd1;
  localparam logic [LAT_W-1:0]     MISS_LAT_RST = 10'd100;

  typedef struct packed {
    logic [HIT_LAT_W-1:0] hit_lat;
    logic [LAT_W-1:0]     miss_lat;
  } cfg_t;

endpackage

/* rtl/direct_mapped_cache_tags.sv */
// Top level of the direct-mapped cache tag store.
//
//  channel | handshake            | payload                                          | dir
//  --------+----------------------+--------------------------------------------------+----
//  input   | in_valid, in_stall   | command, address, entry_select                   | in
//  result  | out_valid, out_stall | hit, tag/set/byte part, refill req/addr, latency | out
//  config  | cfg_we               | cfg_index, cfg_wdata                             | in
//
// One item per cycle sustained while the result channel does not stall. The tag memory is read
// when the input transfers; the lookup stage then compares, updates and loads the result
// register, from which the result transfers once out_stall is low.
// A miss written in the lookup stage is forwarded to a following item of the
// same set, whose memory read would still return the old tag.
// Valid bits sit in flip-flops, so reset and invalidate-all clear them at once.
// A stalled result holds the lookup stage, and the input stalls behind it.
`include "direct_mapped_cache_tags_macros.svh"

module direct_mapped_cache_tags #(
  parameter int ADDR_BITS   = 32,
  parameter int INDEX_BITS  = 6,
  parameter int OFFSET_BITS = 4,
  parameter int TAG_BITS    = 22
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  dmct_pkg::cfg_idx_t               cfg_index,
  input  logic [dmct_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  dmct_pkg::cmd_t                   in_command,
  input  logic [ADDR_BITS-1:0]             in_address,
  input  logic [INDEX_BITS-1:0]            in_entry_select,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [TAG_BITS-1:0]              out_tag_part,
  output logic [INDEX_BITS-1:0]            out_set_part,
  output logic [OFFSET_BITS-1:0]           out_byte_part,
  output logic                             out_refill_request,
  output logic [ADDR_BITS-1:0]             out_refill_address,
  output logic [dmct_pkg::LAT_W-1:0]       out_latency
);
  import dmct_pkg::*;

  localparam int FULL_BITS = TAG_BITS + INDEX_BITS + OFFSET_BITS;
  localparam int WIDE_BITS = (FULL_BITS > ADDR_BITS) ? FULL_BITS : ADDR_BITS;
  localparam int SETS      = 1 << INDEX_BITS;

  cfg_t cfg;

  dmct_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // lookup stage and output registers
  logic                   lk_vld_r, lk_vld_nxt;
  cmd_t                   lk_cmd_r;
  logic [ADDR_BITS-1:0]   lk_addr_r;
  logic [INDEX_BITS-1:0]  lk_sel_r;
  logic                   fwd_r, fwd_nxt;
  logic [TAG_BITS-1:0]    fwd_tag_r;
  logic [SETS-1:0]        valid_r, valid_nxt;
  logic                   out_vld_r, out_vld_nxt;

  logic                   in_xfer;
  logic                   lk_done;
  logic                   inv_all;
  logic [WIDE_BITS-1:0]   in_addr_w;
  logic [INDEX_BITS-1:0]  in_set;
  logic [WIDE_BITS-1:0]   lk_addr_w;
  logic [TAG_BITS-1:0]    lk_tag;
  logic [INDEX_BITS-1:0]  lk_set;
  logic [OFFSET_BITS-1:0] lk_byte;
  logic [FULL_BITS-1:0]   line_full;
  logic [WIDE_BITS-1:0]   line_w;
  logic [TAG_BITS-1:0]    rd_tag;
  logic [TAG_BITS-1:0]    cur_tag;
  logic                   match;
  logic                   wr_en;

  // handshake
  assign lk_done  = lk_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = lk_vld_r && !lk_done;
  assign in_xfer  = in_valid && !in_stall;
  assign inv_all  = lk_done && (lk_cmd_r == CMD_INV_ALL);

  // address split
  assign in_addr_w = WIDE_BITS'(in_address);
  assign in_set    = in_addr_w[OFFSET_BITS +: INDEX_BITS];
  assign lk_addr_w = WIDE_BITS'(lk_addr_r);
  assign lk_tag    = lk_addr_w[OFFSET_BITS + INDEX_BITS +: TAG_BITS];
  assign lk_set    = lk_addr_w[OFFSET_BITS +: INDEX_BITS];
  assign lk_byte   = lk_addr_w[OFFSET_BITS-1:0];
  assign line_full = {lk_tag, lk_set, {OFFSET_BITS{1'b0}}};
  assign line_w    = WIDE_BITS'(line_full);

  dmct_tag_ram #(
    .AW (INDEX_BITS),
    .DW (TAG_BITS)
  ) u_tag_ram (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (in_set),
    .rd_data (rd_tag),
    .wr_en   (wr_en),
    .wr_addr (lk_set),
    .wr_data (lk_tag)
  );

  // compare, with the tag just written taking precedence over the memory read
  assign cur_tag = fwd_r ? fwd_tag_r : rd_tag;
  assign match   = valid_r[lk_set] && (cur_tag == lk_tag);
  assign wr_en   = lk_done && (lk_cmd_r == CMD_ACCESS) && !match;
  assign fwd_nxt = in_xfer && wr_en && (in_set == lk_set);

  // valid bit update
  always_comb begin
    valid_nxt = valid_r;
    if (lk_done) begin
      unique case (lk_cmd_r)
        CMD_ACCESS:  if (!match) valid_nxt[lk_set] = 1'b1;
        CMD_PROBE:   valid_nxt = valid_r;
        CMD_INV_ALL: valid_nxt = '0;
        CMD_INV_ONE: valid_nxt[lk_sel_r] = 1'b0;
        default:     valid_nxt = valid_r;
      endcase
    end
  end

  // stage occupancy
  always_comb begin
    lk_vld_nxt = lk_vld_r;
    if (in_xfer) begin
      lk_vld_nxt = 1'b1;
    end else if (lk_done) begin
      lk_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (lk_done) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_vld_r  <= 1'b0;
      fwd_r     <= 1'b0;
      out_vld_r <= 1'b0;
      valid_r   <= '0;
    end else begin
      lk_vld_r  <= lk_vld_nxt;
      out_vld_r <= out_vld_nxt;
      valid_r   <= valid_nxt;
      if (in_xfer) begin
        fwd_r <= fwd_nxt;
      end
    end
  end

  // lookup stage payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lk_cmd_r  <= in_command;
      lk_addr_r <= in_address;
      lk_sel_r  <= in_entry_select;
      fwd_tag_r <= lk_tag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (lk_done) begin
      out_tag_part  <= lk_tag;
      out_set_part  <= lk_set;
      out_byte_part <= lk_byte;
      unique case (lk_cmd_r)
        CMD_ACCESS, CMD_PROBE: begin
          out_hit            <= match;
          out_refill_request <= (lk_cmd_r == CMD_ACCESS) && !match;
          out_refill_address <= line_w[ADDR_BITS-1:0];
          out_latency        <= match ? LAT_W'(cfg.hit_lat) : cfg.miss_lat;
        end
        default: begin
          out_hit            <= 1'b0;
          out_refill_request <= 1'b0;
          out_refill_address <= '0;
          out_latency        <= '0;
        end
      endcase
    end
  end

  assign out_valid = out_vld_r;

  // checks
  `DMCT_ASSERT_NEXT(a_miss_sets_valid, wr_en, valid_r[$past(lk_set)], "miss left set invalid")
  `DMCT_ASSERT_NEXT(a_inv_all_clears, inv_all, valid_r == '0, "invalidate-all left a valid bit")
  `DMCT_ASSERT_NOW(a_busy_stalls, lk_vld_r && !lk_done, in_stall, "input taken while held")
  `DMCT_ASSERT_NOW(a_fwd_needs_item, fwd_r && lk_done, lk_vld_r, "forward flag without item")

endmodule

/* rtl/dmct_tag_ram.sv */
// Tag memory: one write port, one registered read port.
module dmct_tag_ram #(
  parameter int AW = 6,
  parameter int DW = 22
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [1<<AW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/dmct_cfg_regs.sv */
// Hit and miss latency registers behind the configuration write port.
module dmct_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  dmct_pkg::cfg_idx_t                  cfg_index,
  input  logic [dmct_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output dmct_pkg::cfg_t                      cfg
);
  import dmct_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIT_LAT:  cfg_nxt.hit_lat  = cfg_wdata[HIT_LAT_W-1:0];
        CFG_MISS_LAT: cfg_nxt.miss_lat = cfg_wdata[LAT_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hit_lat  <= HIT_LAT_RST;
      cfg_r.miss_lat <= MISS_LAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
